@@ design/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/psc_pkg.sv @@
package psc_pkg;

   // Coordinates are read as two's complement values of this width from the low field bits.
   localparam int COORD_WIDTH = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int COORD_BITS = (COORD_WIDTH < FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;

   localparam int NORMAL_WIDTH = 18;
   localparam int OFFSET_WIDTH = 32;
   localparam int TOL_WIDTH = 20;
   localparam int RADIUS_WIDTH = 31;
   localparam int DIST_WIDTH = 32;
   localparam int FRAC_BITS = 16;
   localparam int SIDE_WIDTH = 2;
   localparam int ACTION_WIDTH = 2;

   // One normal times one coordinate, and the sum of three of them less the shifted offset.
   localparam int PROD_WIDTH = NORMAL_WIDTH + COORD_BITS;
   localparam int SUM_A = PROD_WIDTH + 2;
   localparam int SUM_B = OFFSET_WIDTH + FRAC_BITS + 1;
   localparam int SUM_WIDTH = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 1;

   // Stream payload widths.
   localparam int REQ_FIELDS_WIDTH = 6 * FIELD_WIDTH + RADIUS_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_WIDTH = SIDE_WIDTH + DIST_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_POINT = 2'd0,
      ACT_SPHERE = 2'd1,
      ACT_BOX = 2'd2
   } action_type;

   typedef enum logic [SIDE_WIDTH-1:0] {
      SIDE_FRONT = 2'd0,
      SIDE_BEHIND = 2'd1,
      SIDE_ON = 2'd2
   } side_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NORMAL_X = 3'd0,
      CSR_NORMAL_Y = 3'd1,
      CSR_NORMAL_Z = 3'd2,
      CSR_PLANE_OFFSET = 3'd3,
      CSR_TOLERANCE = 3'd4
   } csr_index_type;

endpackage

@@ design/plane_side_classifier_unit.sv @@
// Plane side classifier: a four-stage pipeline that takes one request per cycle unless the
// output stalls, and returns one response per request. A request passes through the select,
// product, sum and result registers in that order, and the result register drives the response.
// The stages are operand selection, three pairs of 18 x 32 bit normal-times-coordinate
// multiplies, the dot product sums less the offset, and the final compare with saturation of
// the distance. Every stage passes one request per cycle unless the output stalls, so requests
// can follow back to back. A stalled response holds in the output register while earlier stages
// keep filling, and the request side stops only once all four stages hold a request.
// The plane and tolerance registers are written through the csr channel, which is always ready.
module plane_side_classifier_unit
   import psc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // From bit 0: first_x, first_y, first_z, second_x, second_y, second_z, radius, zero fill.
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // From bit 0: action.
   input  logic [ACTION_WIDTH-1:0]    req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // From bit 0: side, signed_distance, zero fill.
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   typedef struct packed {
      logic [ACTION_WIDTH-1:0]     action;
      logic signed [COORD_BITS-1:0] near_x;
      logic signed [COORD_BITS-1:0] near_y;
      logic signed [COORD_BITS-1:0] near_z;
      logic signed [COORD_BITS-1:0] far_x;
      logic signed [COORD_BITS-1:0] far_y;
      logic signed [COORD_BITS-1:0] far_z;
      logic signed [SUM_WIDTH-1:0]  thr;
      logic signed [SUM_WIDTH-1:0]  neg_thr;
   } select_stage_type;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0]      action;
      logic signed [PROD_WIDTH-1:0] near_x;
      logic signed [PROD_WIDTH-1:0] near_y;
      logic signed [PROD_WIDTH-1:0] near_z;
      logic signed [PROD_WIDTH-1:0] far_x;
      logic signed [PROD_WIDTH-1:0] far_y;
      logic signed [PROD_WIDTH-1:0] far_z;
      logic signed [SUM_WIDTH-1:0]  thr;
      logic signed [SUM_WIDTH-1:0]  neg_thr;
   } product_stage_type;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0]     action;
      logic signed [SUM_WIDTH-1:0] near_sum;
      logic signed [SUM_WIDTH-1:0] far_sum;
      logic signed [SUM_WIDTH-1:0] thr;
      logic signed [SUM_WIDTH-1:0] neg_thr;
   } sum_stage_type;

   typedef struct packed {
      logic [SIDE_WIDTH-1:0] side;
      logic [DIST_WIDTH-1:0] distance;
   } result_stage_type;

   localparam int RSP_PAD = RSP_TDATA_WIDTH - RSP_FIELDS_WIDTH;
   localparam int SAT_TOP = SUM_WIDTH - FRAC_BITS - DIST_WIDTH + 1;

   // Configuration registers.
   logic signed [NORMAL_WIDTH-1:0] normal_x_ff, normal_x_in;
   logic signed [NORMAL_WIDTH-1:0] normal_y_ff, normal_y_in;
   logic signed [NORMAL_WIDTH-1:0] normal_z_ff, normal_z_in;
   logic signed [OFFSET_WIDTH-1:0] plane_offset_ff, plane_offset_in;
   logic [TOL_WIDTH-1:0]           tolerance_ff, tolerance_in;

   // Pipeline registers and their valid bits.
   logic              sel_valid_ff, sel_valid_in;
   logic              prod_valid_ff, prod_valid_in;
   logic              sum_valid_ff, sum_valid_in;
   logic              res_valid_ff, res_valid_in;
   select_stage_type  sel_ff, sel_in;
   product_stage_type prod_ff, prod_in;
   sum_stage_type     sum_ff, sum_in;
   result_stage_type  res_ff, res_in;

   logic sel_ready, prod_ready, sum_ready, res_ready;
   logic req_accept;

   // Unpacked request fields.
   logic signed [COORD_BITS-1:0] first_x, first_y, first_z;
   logic signed [COORD_BITS-1:0] second_x, second_y, second_z;
   logic [RADIUS_WIDTH-1:0]      radius;
   logic                         pos_x, pos_y, pos_z;
   logic signed [SUM_WIDTH-1:0]  offset_term;
   logic [SAT_TOP-1:0]           sat_bits;
   logic [DIST_WIDTH-1:0]        dist_sat;

   assign first_x  = req_tdata[0*FIELD_WIDTH +: COORD_BITS];
   assign first_y  = req_tdata[1*FIELD_WIDTH +: COORD_BITS];
   assign first_z  = req_tdata[2*FIELD_WIDTH +: COORD_BITS];
   assign second_x = req_tdata[3*FIELD_WIDTH +: COORD_BITS];
   assign second_y = req_tdata[4*FIELD_WIDTH +: COORD_BITS];
   assign second_z = req_tdata[5*FIELD_WIDTH +: COORD_BITS];
   assign radius   = req_tdata[6*FIELD_WIDTH +: RADIUS_WIDTH];

   // Each stage takes new data when it is empty or its contents move on.
   assign res_ready  = !res_valid_ff || rsp_tready;
   assign sum_ready  = !sum_valid_ff || res_ready;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign sel_ready  = !sel_valid_ff || prod_ready;
   assign req_tready = sel_ready;
   assign req_accept = req_tvalid && sel_ready;

   assign csr_ready = 1'b1;

   // Register writes, masked to the register width; unknown indexes are ignored.
   always_comb begin
      normal_x_in     = normal_x_ff;
      normal_y_in     = normal_y_ff;
      normal_z_in     = normal_z_ff;
      plane_offset_in = plane_offset_ff;
      tolerance_in    = tolerance_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NORMAL_X: begin
               normal_x_in = csr_data[NORMAL_WIDTH-1:0];
            end
            CSR_NORMAL_Y: begin
               normal_y_in = csr_data[NORMAL_WIDTH-1:0];
            end
            CSR_NORMAL_Z: begin
               normal_z_in = csr_data[NORMAL_WIDTH-1:0];
            end
            CSR_PLANE_OFFSET: begin
               plane_offset_in = csr_data[OFFSET_WIDTH-1:0];
            end
            CSR_TOLERANCE: begin
               tolerance_in = csr_data[TOL_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A strictly positive normal component pairs the box minimum with the near corner.
   assign pos_x = !normal_x_ff[NORMAL_WIDTH-1] && (normal_x_ff != '0);
   assign pos_y = !normal_y_ff[NORMAL_WIDTH-1] && (normal_y_ff != '0);
   assign pos_z = !normal_z_ff[NORMAL_WIDTH-1] && (normal_z_ff != '0);

   // Stage one: pick the corners and the threshold scaled to the product fraction.
   always_comb begin
      sel_valid_in = sel_ready ? req_tvalid : sel_valid_ff;
      sel_in = sel_ff;
      if (req_accept) begin
         sel_in.action = req_tuser;
         if (req_tuser == ACT_BOX) begin
            sel_in.near_x = pos_x ? first_x : second_x;
            sel_in.near_y = pos_y ? first_y : second_y;
            sel_in.near_z = pos_z ? first_z : second_z;
            sel_in.far_x  = pos_x ? second_x : first_x;
            sel_in.far_y  = pos_y ? second_y : first_y;
            sel_in.far_z  = pos_z ? second_z : first_z;
         end else begin
            sel_in.near_x = first_x;
            sel_in.near_y = first_y;
            sel_in.near_z = first_z;
            sel_in.far_x  = first_x;
            sel_in.far_y  = first_y;
            sel_in.far_z  = first_z;
         end
         if (req_tuser == ACT_SPHERE) begin
            sel_in.thr = SUM_WIDTH'(radius) << FRAC_BITS;
         end else begin
            sel_in.thr = SUM_WIDTH'(tolerance_ff) << FRAC_BITS;
         end
         sel_in.neg_thr = -sel_in.thr;
      end
   end

   // Stage two: the six normal-times-coordinate products.
   always_comb begin
      prod_valid_in = prod_ready ? sel_valid_ff : prod_valid_ff;
      prod_in = prod_ff;
      if (prod_ready && sel_valid_ff) begin
         prod_in.action  = sel_ff.action;
         prod_in.near_x  = $signed(normal_x_ff) * $signed(sel_ff.near_x);
         prod_in.near_y  = $signed(normal_y_ff) * $signed(sel_ff.near_y);
         prod_in.near_z  = $signed(normal_z_ff) * $signed(sel_ff.near_z);
         prod_in.far_x   = $signed(normal_x_ff) * $signed(sel_ff.far_x);
         prod_in.far_y   = $signed(normal_y_ff) * $signed(sel_ff.far_y);
         prod_in.far_z   = $signed(normal_z_ff) * $signed(sel_ff.far_z);
         prod_in.thr     = sel_ff.thr;
         prod_in.neg_thr = sel_ff.neg_thr;
      end
   end

   // Stage three: dot products less the offset, kept exact with sixteen fraction bits.
   assign offset_term = SUM_WIDTH'(plane_offset_ff) <<< FRAC_BITS;

   always_comb begin
      sum_valid_in = sum_ready ? prod_valid_ff : sum_valid_ff;
      sum_in = sum_ff;
      if (sum_ready && prod_valid_ff) begin
         sum_in.action   = prod_ff.action;
         sum_in.near_sum = $signed(prod_ff.near_x) + $signed(prod_ff.near_y)
                         + $signed(prod_ff.near_z) - offset_term;
         sum_in.far_sum  = $signed(prod_ff.far_x) + $signed(prod_ff.far_y)
                         + $signed(prod_ff.far_z) - offset_term;
         sum_in.thr      = prod_ff.thr;
         sum_in.neg_thr  = prod_ff.neg_thr;
      end
   end

   // Whole part of the distance, rounded down and saturated to the output width.
   assign sat_bits = sum_ff.near_sum[SUM_WIDTH-1:FRAC_BITS+DIST_WIDTH-1];

   always_comb begin
      if ((sat_bits == '0) || (sat_bits == '1)) begin
         dist_sat = sum_ff.near_sum[FRAC_BITS +: DIST_WIDTH];
      end else if (sum_ff.near_sum[SUM_WIDTH-1]) begin
         dist_sat = {1'b1, {(DIST_WIDTH-1){1'b0}}};
      end else begin
         dist_sat = {1'b0, {(DIST_WIDTH-1){1'b1}}};
      end
   end

   // Stage four: side decision per item kind.
   always_comb begin
      res_valid_in = res_ready ? sum_valid_ff : res_valid_ff;
      res_in = res_ff;
      if (res_ready && sum_valid_ff) begin
         res_in.side = SIDE_ON;
         res_in.distance = '0;
         case (sum_ff.action)
            ACT_POINT: begin
               if (sum_ff.near_sum > sum_ff.thr) begin
                  res_in.side = SIDE_FRONT;
               end else if (sum_ff.near_sum < sum_ff.neg_thr) begin
                  res_in.side = SIDE_BEHIND;
               end
               res_in.distance = dist_sat;
            end
            ACT_SPHERE: begin
               if (sum_ff.near_sum >= sum_ff.thr) begin
                  res_in.side = SIDE_FRONT;
               end else if (sum_ff.near_sum <= sum_ff.neg_thr) begin
                  res_in.side = SIDE_BEHIND;
               end
               res_in.distance = dist_sat;
            end
            ACT_BOX: begin
               if (!sum_ff.near_sum[SUM_WIDTH-1]) begin
                  res_in.side = SIDE_FRONT;
               end else if (sum_ff.far_sum[SUM_WIDTH-1] || (sum_ff.far_sum == '0)) begin
                  res_in.side = SIDE_BEHIND;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control state and configuration reset; payload registers load only.
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_x_ff     <= '0;
         normal_y_ff     <= '0;
         normal_z_ff     <= NORMAL_WIDTH'(1 << FRAC_BITS);
         plane_offset_ff <= '0;
         tolerance_ff    <= TOL_WIDTH'(66);
         sel_valid_ff    <= 1'b0;
         prod_valid_ff   <= 1'b0;
         sum_valid_ff    <= 1'b0;
         res_valid_ff    <= 1'b0;
      end else begin
         normal_x_ff     <= normal_x_in;
         normal_y_ff     <= normal_y_in;
         normal_z_ff     <= normal_z_in;
         plane_offset_ff <= plane_offset_in;
         tolerance_ff    <= tolerance_in;
         sel_valid_ff    <= sel_valid_in;
         prod_valid_ff   <= prod_valid_in;
         sum_valid_ff    <= sum_valid_in;
         res_valid_ff    <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff  <= sel_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      res_ff  <= res_in;
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, res_ff.distance, res_ff.side};

endmodule

@@ design/psc_checker.sv @@
`include "assert_macros.svh"

module psc_checker
   import psc_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   // A response that is not taken stays and keeps its payload.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // Reset empties the pipeline.
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_tvalid, "response valid right after reset")

   // With the output free the whole pipeline can take a request.
   `ASSERT_CLK_RST(a_req_ready, clock, reset, !rsp_tvalid || rsp_tready |-> req_tready, "request refused while output is free")

   // A front result never carries a negative distance.
   `ASSERT_CLK_RST(a_front_sign, clock, reset, rsp_tvalid && (rsp_tdata[SIDE_WIDTH-1:0] == SIDE_FRONT) |-> !rsp_tdata[SIDE_WIDTH+DIST_WIDTH-1], "front side with negative distance")

   // The side code is never the unused one.
   `ASSERT_CLK_RST(a_side_code, clock, reset, rsp_tvalid |-> (rsp_tdata[SIDE_WIDTH-1:0] == SIDE_FRONT) || (rsp_tdata[SIDE_WIDTH-1:0] == SIDE_BEHIND) || (rsp_tdata[SIDE_WIDTH-1:0] == SIDE_ON), "unused side code")

endmodule

bind plane_side_classifier_unit psc_checker u_psc_checker (.*);

@@ sim/tb_plane_side_classifier_unit.sv @@
`timescale 1ns / 100ps

module tb_plane_side_classifier_unit;
   import psc_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 12;
   localparam int PHASE_COUNT = 8;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 12;
   localparam logic [ACTION_WIDTH-1:0] ACTION_UNUSED = 2'd3;
   localparam longint DIST_HIGH = (longint'(1) <<< (DIST_WIDTH - 1)) - 1;
   localparam longint DIST_LOW = -(longint'(1) <<< (DIST_WIDTH - 1));

   // One shape as it travels in a request.
   typedef struct {
      logic [ACTION_WIDTH-1:0]      action;
      logic signed [FIELD_WIDTH-1:0] first [3];
      logic signed [FIELD_WIDTH-1:0] second [3];
      logic [RADIUS_WIDTH-1:0]      radius;
   } shape_request_type;

   typedef struct {
      side_type                     side;
      logic signed [DIST_WIDTH-1:0] distance;
   } side_report_type;

   typedef struct {
      shape_request_type shape;
      bit                typed;
      side_report_type   want;
   } probe_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic [ACTION_WIDTH-1:0]    req_tuser = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Shadow copy of the plane registers, starting from their reset values.
   logic signed [NORMAL_WIDTH-1:0] plane_normal [3] = '{18'sd0, 18'sd0, 18'sd65536};
   logic signed [OFFSET_WIDTH-1:0] plane_offset = '0;
   logic [TOL_WIDTH-1:0]           plane_tolerance = 20'd66;

   side_report_type pending_sides [$];
   probe_type       probes [$];
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   int unsigned     sender_idle_pct = 0;
   int unsigned     receiver_stall_pct = 0;

   plane_side_classifier_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // The receiver stalls at random with the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   function automatic logic signed [DIST_WIDTH-1:0] clamp32(longint v);
      if (v > DIST_HIGH) return DIST_HIGH[DIST_WIDTH-1:0];
      if (v < DIST_LOW) return DIST_LOW[DIST_WIDTH-1:0];
      return v[DIST_WIDTH-1:0];
   endfunction

   // Exact dot(n, c) - d in units of 2^-16: Q1.16 times Q31.0, offset moved up 16 bits.
   function automatic longint plane_excess(input logic signed [FIELD_WIDTH-1:0] c [3]);
      longint acc = -(longint'(plane_offset) <<< FRAC_BITS);
      for (int i = 0; i < 3; i++) acc += longint'(plane_normal[i]) * longint'(c[i]);
      return acc;
   endfunction

   // Predicts the side and the distance for one shape under the shadow registers.
   function automatic side_report_type classify_shape(shape_request_type s);
      side_report_type r;
      logic signed [FIELD_WIDTH-1:0] near_c [3];
      logic signed [FIELD_WIDTH-1:0] far_c [3];
      longint excess;
      longint band;
      r.side = SIDE_ON;
      r.distance = '0;
      case (s.action)
         ACT_POINT: begin
            excess = plane_excess(s.first);
            band = longint'(plane_tolerance) <<< FRAC_BITS;
            if (excess > band) r.side = SIDE_FRONT;
            else if (excess < -band) r.side = SIDE_BEHIND;
            r.distance = clamp32(excess >>> FRAC_BITS);
         end
         ACT_SPHERE: begin
            excess = plane_excess(s.first);
            band = longint'(s.radius) <<< FRAC_BITS;
            if (excess >= band) r.side = SIDE_FRONT;
            else if (excess <= -band) r.side = SIDE_BEHIND;
            r.distance = clamp32(excess >>> FRAC_BITS);
         end
         ACT_BOX: begin
            // A positive normal component takes the minimum as the near corner.
            for (int i = 0; i < 3; i++) begin
               near_c[i] = (plane_normal[i] > 0) ? s.first[i] : s.second[i];
               far_c[i] = (plane_normal[i] > 0) ? s.second[i] : s.first[i];
            end
            if (plane_excess(near_c) >= 0) r.side = SIDE_FRONT;
            else if (plane_excess(far_c) <= 0) r.side = SIDE_BEHIND;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic shape_request_type shape(logic [ACTION_WIDTH-1:0] action,
                                            logic [FIELD_WIDTH-1:0] fx, logic [FIELD_WIDTH-1:0] fy,
                                            logic [FIELD_WIDTH-1:0] fz, logic [FIELD_WIDTH-1:0] sx,
                                            logic [FIELD_WIDTH-1:0] sy, logic [FIELD_WIDTH-1:0] sz,
                                            logic [RADIUS_WIDTH-1:0] radius);
      shape_request_type s;
      s.action = action;
      s.first = '{fx, fy, fz};
      s.second = '{sx, sy, sz};
      s.radius = radius;
      return s;
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] any_coord();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(FIELD_WIDTH - 1){1'b0}}};
         1: return {1'b0, {(FIELD_WIDTH - 1){1'b1}}};
         2: return '0;
         3: return FIELD_WIDTH'($urandom_range(0, 2047)) - FIELD_WIDTH'(1024);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [RADIUS_WIDTH-1:0] any_radius();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return RADIUS_WIDTH'($urandom_range(0, 4095));
         default: return RADIUS_WIDTH'($urandom);
      endcase
   endfunction

   // Uniform value in [-m, m].
   function automatic longint spread(longint m);
      longint unsigned raw = {$urandom, $urandom};
      longint unsigned span = 2 * m + 1;
      return longint'(raw % span) - m;
   endfunction

   // Picks a plane excess on, just beside, or around the edges of a band, or anywhere across it.
   function automatic longint near_offset(longint band);
      case ($urandom_range(0, 4))
         0: return band;
         1: return -band;
         2: return band + spread(longint'(1) <<< (FRAC_BITS + 1));
         3: return -band + spread(longint'(1) <<< (FRAC_BITS + 1));
         default: return spread(2 * band + (longint'(1) <<< (FRAC_BITS + 2)));
      endcase
   endfunction

   // Moves the first corner so that its plane excess lands near the target.
   function automatic shape_request_type aim_at_plane(shape_request_type s, longint target);
      longint rest = target + (longint'(plane_offset) <<< FRAC_BITS);
      int axis = -1;
      for (int i = 0; i < 3; i++) if (plane_normal[i] != 0) axis = i;
      if (axis < 0) return s;
      for (int i = 0; i < 3; i++) begin
         if (i != axis) begin
            s.first[i] = FIELD_WIDTH'($urandom_range(0, 2 ** 21)) - FIELD_WIDTH'(2 ** 20);
            rest -= longint'(plane_normal[i]) * longint'(s.first[i]);
         end
      end
      s.first[axis] = clamp32(rest / longint'(plane_normal[axis]));
      return s;
   endfunction

   function automatic shape_request_type random_shape();
      shape_request_type s;
      int unsigned pick = $urandom_range(0, 99);
      longint band;
      logic [FIELD_WIDTH-1:0] reach;
      if (pick < 4) s.action = ACTION_UNUSED;
      else if (pick < 36) s.action = ACT_POINT;
      else if (pick < 68) s.action = ACT_SPHERE;
      else s.action = ACT_BOX;
      for (int i = 0; i < 3; i++) begin
         s.first[i] = any_coord();
         s.second[i] = any_coord();
      end
      s.radius = any_radius();
      // Half of the shapes are placed close to the plane so all sides show up.
      if ($urandom_range(0, 1) == 1 && s.action != ACTION_UNUSED) begin
         case (s.action)
            ACT_POINT: band = longint'(plane_tolerance) <<< FRAC_BITS;
            ACT_SPHERE: band = longint'(s.radius) <<< FRAC_BITS;
            default: band = longint'($urandom_range(0, 2 ** 20)) <<< FRAC_BITS;
         endcase
         s = aim_at_plane(s, near_offset(band));
         if (s.action == ACT_BOX) begin
            for (int i = 0; i < 3; i++) begin
               reach = FIELD_WIDTH'($urandom_range(0, 2 ** 20));
               if ($urandom_range(0, 7) == 0) reach = -reach;
               s.second[i] = s.first[i] + reach;
               s.first[i] = s.first[i] - reach;
            end
         end
      end
      return s;
   endfunction

   // Keeps the low bits of a register value and fills the rest with noise.
   function automatic logic [CSR_DATA_WIDTH-1:0] pad_noise(logic [CSR_DATA_WIDTH-1:0] v, int w);
      logic [CSR_DATA_WIDTH-1:0] keep = (w >= CSR_DATA_WIDTH) ? '1 : ((32'd1 << w) - 1);
      return (v & keep) | ($urandom & ~keep);
   endfunction

   // Sends one shape and returns at the edge where the request is taken.
   task automatic issue_request(shape_request_type s);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= s.action;
      req_tdata <= {{(REQ_TDATA_WIDTH - REQ_FIELDS_WIDTH){1'b0}}, s.radius,
                    s.second[2], s.second[1], s.second[0], s.first[2], s.first[1], s.first[0]};
      do @(posedge clock); while (!req_tready);
   endtask

   // Leaves csr_valid high so that writes can follow back to back.
   task automatic put_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NORMAL_X: plane_normal[0] = value[NORMAL_WIDTH-1:0];
         CSR_NORMAL_Y: plane_normal[1] = value[NORMAL_WIDTH-1:0];
         CSR_NORMAL_Z: plane_normal[2] = value[NORMAL_WIDTH-1:0];
         CSR_PLANE_OFFSET: plane_offset = value[OFFSET_WIDTH-1:0];
         CSR_TOLERANCE: plane_tolerance = value[TOL_WIDTH-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_sides.size() != 0) @(posedge clock);
   endtask

   // Every response is matched against the oldest prediction.
   always @(posedge clock) begin : response_check
      side_report_type want;
      logic [SIDE_WIDTH-1:0] got_side;
      logic signed [DIST_WIDTH-1:0] got_dist;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_side = rsp_tdata[SIDE_WIDTH-1:0];
         got_dist = rsp_tdata[SIDE_WIDTH +: DIST_WIDTH];
         if (pending_sides.size() == 0) begin
            $display("%0t: response without a request: side %0d distance %0d",
                     $time, got_side, got_dist);
            mismatch_count++;
         end else begin
            want = pending_sides.pop_front();
            if (got_side !== want.side) begin
               $display("%0t: side expected %0d actual %0d", $time, want.side, got_side);
               mismatch_count++;
            end
            if (got_dist !== want.distance) begin
               $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                        got_dist);
               mismatch_count++;
            end
         end
      end
   end

   // Ends a hung run: no request, response or register write for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_WIDTH-1:0] normal_raw [3];
      logic [CSR_DATA_WIDTH-1:0] offset_raw;
      logic [CSR_DATA_WIDTH-1:0] tolerance_raw;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed shapes under the reset plane z = 0 with tolerance 66: point and sphere distance equals first_z.
      probes.push_back('{shape(ACT_POINT, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{SIDE_ON, 32'sd0}});
      probes.push_back('{shape(ACT_POINT, 32'h8000_0000, 32'h7fff_ffff, 66, 0, 0, 0, 0),
                         1'b1, '{SIDE_ON, 32'sd66}});
      probes.push_back('{shape(ACT_POINT, 32'h7fff_ffff, 32'h8000_0000, 67, 0, 0, 0, 0),
                         1'b1, '{SIDE_FRONT, 32'sd67}});
      probes.push_back('{shape(ACT_POINT, 0, 0, -32'sd66, 0, 0, 0, 0), 1'b1, '{SIDE_ON, -32'sd66}});
      probes.push_back('{shape(ACT_POINT, 0, 0, -32'sd67, 0, 0, 0, 0),
                         1'b1, '{SIDE_BEHIND, -32'sd67}});
      probes.push_back('{shape(ACT_POINT, -1, -1, 32'h7fff_ffff, -1, -1, -1, '1),
                         1'b1, '{SIDE_FRONT, 32'h7fff_ffff}});
      probes.push_back('{shape(ACT_POINT, 0, 0, 32'h8000_0000, 0, 0, 0, 0),
                         1'b1, '{SIDE_BEHIND, 32'h8000_0000}});
      probes.push_back('{shape(ACT_SPHERE, 0, 0, 100, 0, 0, 0, 100),
                         1'b1, '{SIDE_FRONT, 32'sd100}});
      probes.push_back('{shape(ACT_SPHERE, 0, 0, -32'sd100, 0, 0, 0, 100),
                         1'b1, '{SIDE_BEHIND, -32'sd100}});
      probes.push_back('{shape(ACT_SPHERE, 0, 0, 99, 0, 0, 0, 100), 1'b1, '{SIDE_ON, 32'sd99}});
      probes.push_back('{shape(ACT_SPHERE, 0, 0, -32'sd99, 0, 0, 0, 100),
                         1'b1, '{SIDE_ON, -32'sd99}});
      probes.push_back('{shape(ACT_SPHERE, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{SIDE_FRONT, 32'sd0}});
      probes.push_back('{shape(ACT_SPHERE, 0, 0, 32'h7fff_ffff, 0, 0, 0, '1),
                         1'b1, '{SIDE_FRONT, 32'h7fff_ffff}});
      probes.push_back('{shape(ACT_SPHERE, 0, 0, 32'h8000_0000, 0, 0, 0, '1),
                         1'b1, '{SIDE_BEHIND, 32'h8000_0000}});
      probes.push_back('{shape(ACT_SPHERE, 0, 0, 32'h8000_0001, 0, 0, 0, '1),
                         1'b1, '{SIDE_BEHIND, 32'h8000_0001}});
      probes.push_back('{shape(ACT_BOX, 0, 0, 0, 0, 0, 10, 0), 1'b1, '{SIDE_FRONT, 32'sd0}});
      probes.push_back('{shape(ACT_BOX, 0, 0, -32'sd10, 0, 0, 0, 0),
                         1'b1, '{SIDE_BEHIND, 32'sd0}});
      probes.push_back('{shape(ACT_BOX, 0, 0, -32'sd10, 0, 0, 10, 0), 1'b1, '{SIDE_ON, 32'sd0}});
      // Inverted boxes are taken as given.
      probes.push_back('{shape(ACT_BOX, 0, 0, 10, 0, 0, -32'sd10, 0),
                         1'b1, '{SIDE_FRONT, 32'sd0}});
      probes.push_back('{shape(ACT_BOX, 0, 0, -32'sd5, 0, 0, -32'sd20, 0),
                         1'b1, '{SIDE_BEHIND, 32'sd0}});
      probes.push_back('{shape(ACT_BOX, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, '1),
                         1'b1, '{SIDE_ON, 32'sd0}});
      // The unused action code reports on-plane with zero distance.
      probes.push_back('{shape(ACTION_UNUSED, -1, -1, -1, -1, -1, -1, '1),
                         1'b1, '{SIDE_ON, 32'sd0}});
      probes.push_back('{shape(ACTION_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, RADIUS_WIDTH'($urandom)), 1'b1, '{SIDE_ON, 32'sd0}});
      probes.push_back('{shape(ACT_SPHERE, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, RADIUS_WIDTH'($urandom)), 1'b0, '{SIDE_ON, 32'sd0}});
      probes.push_back('{shape(ACT_BOX, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, RADIUS_WIDTH'($urandom)), 1'b0, '{SIDE_ON, 32'sd0}});

      foreach (probes[i]) begin
         issue_request(probes[i].shape);
         pending_sides.push_back(probes[i].typed ? probes[i].want : classify_shape(probes[i].shape));
      end

      // Random phases, each with its own plane and one of four idle patterns.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_results();
         case (ph % 4)
            0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            1: begin sender_idle_pct = 53; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 53; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase
         case (ph)
            0: begin
               normal_raw = '{32'h2_0000, 32'h1_ffff, 32'h2_0000};
               offset_raw = 32'h8000_0000;
               tolerance_raw = 32'hf_ffff;
            end
            1: begin
               normal_raw = '{32'h1_ffff, 32'h1_ffff, 32'h1_ffff};
               offset_raw = 32'h7fff_ffff;
               tolerance_raw = '0;
            end
            2: begin
               normal_raw = '{32'h0, 32'h0, 32'h0};
               offset_raw = '0;
               tolerance_raw = '0;
            end
            3: begin
               normal_raw = '{32'h0, 32'h0, 32'h1_0000};
               offset_raw = CSR_DATA_WIDTH'($urandom_range(0, 4095)) - CSR_DATA_WIDTH'(2048);
               tolerance_raw = $urandom_range(0, 300);
            end
            default: begin
               foreach (normal_raw[i]) normal_raw[i] = $urandom;
               offset_raw = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 2 ** 20);
               tolerance_raw = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 1000);
            end
         endcase
         put_register(CSR_NORMAL_X, pad_noise(normal_raw[0], NORMAL_WIDTH));
         put_register(CSR_NORMAL_Y, pad_noise(normal_raw[1], NORMAL_WIDTH));
         put_register(CSR_NORMAL_Z, pad_noise(normal_raw[2], NORMAL_WIDTH));
         put_register(CSR_PLANE_OFFSET, offset_raw);
         put_register(CSR_TOLERANCE, pad_noise(tolerance_raw, TOL_WIDTH));
         // Writes to indexes past the register list must change nothing.
         for (int i = CSR_TOLERANCE + 1; i < 2 ** CSR_INDEX_WIDTH; i++)
            put_register(CSR_INDEX_WIDTH'(i), $urandom);
         csr_valid <= 1'b0;

         repeat (ITEMS_PER_PHASE) begin
            shape_request_type s;
            s = random_shape();
            issue_request(s);
            pending_sides.push_back(classify_shape(s));
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_sides.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
